[hw/rtl/vpa_pkg.sv]
package vpa_pkg;

   localparam int MEM_UNITS = 512;
   localparam int MAX_SEGS  = 64;
   localparam int MAX_PROCS = 64;

   localparam int SIZE_W     = 10;
   localparam int ID_W       = 8;
   localparam int SEG_IDX_W  = $clog2(MAX_SEGS);
   localparam int PROC_IDX_W = $clog2(MAX_PROCS);
   localparam int SEG_CNT_W  = $clog2(MAX_SEGS + 1);
   localparam int PROC_CNT_W = $clog2(MAX_PROCS + 1);

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FIT  = 2'd1;
   localparam logic [1:0] ST_NO_PROC = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } seg_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   owner;
      logic [SIZE_W-1:0] start;
      logic [SIZE_W-1:0] len;
   } proc_entry_type;

   localparam int SEG_ENTRY_W  = $bits(seg_entry_type);
   localparam int PROC_ENTRY_W = $bits(proc_entry_type);

endpackage

[hw/rtl/vpa_ram.sv]
module vpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/variable_partition_allocator.sv]
// channel   ports                                        handshake
// request   req_kind, req_proc_id, req_req_size          start && !busy
// response  rsp_status, rsp_start_addr, rsp_block_size   rsp_valid, one cycle
// csr       csr_fit_policy                               csr_we
//
// Each item is walked over two tables with separate read and write ports and a
// registered read; every segment visited, process record visited or entry moved
// takes a read state and then an evaluate or write state. Allocate time grows
// with segments scanned and entries shifted; release time with segments and records.
// After reset the S_INIT state writes the initial segment; busy is high meanwhile.
// The response cannot be stalled; busy drops in the cycle rsp_valid is high.
module variable_partition_allocator
   import vpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic [ID_W-1:0]   req_proc_id,
   input  logic [SIZE_W-1:0] req_req_size,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [SIZE_W-1:0] rsp_start_addr,
   output logic [SIZE_W-1:0] rsp_block_size,
   input  logic              csr_we,
   input  logic [1:0]        csr_fit_policy
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_A_RD, S_A_EV, S_A_CHK, S_A_UPRD, S_A_UPWR, S_A_NEW, S_A_PROC,
      S_R_PRD, S_R_PEV, S_R_SRD, S_R_SEV, S_R_NRD, S_R_NEV, S_R_PRV, S_R_PJ,
      S_SD_RD, S_SD_WR, S_P_RD, S_P_WR
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            policy_ff, policy_in;
   logic [SEG_CNT_W-1:0]  seg_count_ff, seg_count_in;
   logic [PROC_CNT_W-1:0] proc_count_ff, proc_count_in;
   logic [SEG_CNT_W-1:0]  idx_ff, idx_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [SIZE_W-1:0]     req_ff, req_in;
   logic [SIZE_W-1:0]     addr_ff, addr_in;
   logic                  found_ff, found_in;
   logic [SEG_IDX_W-1:0]  pick_ff, pick_in;
   logic [SIZE_W-1:0]     pick_addr_ff, pick_addr_in;
   logic [SIZE_W-1:0]     pick_left_ff, pick_left_in;
   logic [SIZE_W-1:0]     pick_size_ff, pick_size_in;
   logic [PROC_IDX_W-1:0] pj_ff, pj_in;
   logic [SIZE_W-1:0]     st_ff, st_in;
   logic [SIZE_W-1:0]     len_ff, len_in;
   logic [SEG_IDX_W-1:0]  k_ff, k_in;
   logic [SIZE_W-1:0]     ksize_ff, ksize_in;
   logic                  prev_free_ff, prev_free_in;
   logic [SIZE_W-1:0]     prev_size_ff, prev_size_in;
   logic                  sd_ret_ff, sd_ret_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]     rsp_size_ff, rsp_size_in;

   logic                  seg_we;
   logic [SEG_IDX_W-1:0]  seg_wa, seg_ra;
   seg_entry_type         seg_wd, seg_rd;
   logic                  proc_we;
   logic [PROC_IDX_W-1:0] proc_wa, proc_ra;
   proc_entry_type        proc_wd, proc_rd;

   logic                  first_fit;
   logic                  take;
   logic [SIZE_W-1:0]     left;
   logic [SIZE_W-1:0]     merged;

   vpa_ram #(.WIDTH(SEG_ENTRY_W), .DEPTH(MAX_SEGS)) u_seg_ram (
      .clock (clock),
      .we    (seg_we),
      .waddr (seg_wa),
      .wdata (seg_wd),
      .raddr (seg_ra),
      .rdata (seg_rd)
   );

   vpa_ram #(.WIDTH(PROC_ENTRY_W), .DEPTH(MAX_PROCS)) u_proc_ram (
      .clock (clock),
      .we    (proc_we),
      .waddr (proc_wa),
      .wdata (proc_wd),
      .raddr (proc_ra),
      .rdata (proc_rd)
   );

   assign first_fit = !(policy_ff == POL_BEST || policy_ff == POL_WORST);
   assign left      = seg_rd.size - req_ff;
   assign merged    = ksize_ff + seg_rd.size + SIZE_W'(1);

   always_comb begin
      unique case (policy_ff)
         POL_BEST:  take = !found_ff || (left < pick_left_ff);
         POL_WORST: take = !found_ff || (left >= pick_left_ff);
         default:   take = 1'b1;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      policy_in     = csr_we ? csr_fit_policy : policy_ff;
      seg_count_in  = seg_count_ff;
      proc_count_in = proc_count_ff;
      idx_in        = idx_ff;
      id_in         = id_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_addr_in  = pick_addr_ff;
      pick_left_in  = pick_left_ff;
      pick_size_in  = pick_size_ff;
      pj_in         = pj_ff;
      st_in         = st_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      ksize_in      = ksize_ff;
      prev_free_in  = prev_free_ff;
      prev_size_in  = prev_size_ff;
      sd_ret_in     = sd_ret_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      seg_we        = 1'b0;
      seg_wa        = '0;
      seg_wd        = '0;
      seg_ra        = idx_ff[SEG_IDX_W-1:0];
      proc_we       = 1'b0;
      proc_wa       = '0;
      proc_wd       = '0;
      proc_ra       = idx_ff[PROC_IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            seg_we      = 1'b1;
            seg_wd.used = 1'b0;
            seg_wd.size = SIZE_W'(MEM_UNITS);
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               id_in    = req_proc_id;
               req_in   = req_req_size;
               idx_in   = '0;
               addr_in  = '0;
               found_in = 1'b0;
               prev_free_in = 1'b0;
               state_in = (req_kind == KIND_ALLOC) ? S_A_RD : S_R_PRD;
            end
         end
         S_A_RD: begin
            state_in = (idx_ff == seg_count_ff) ? S_A_CHK : S_A_EV;
         end
         S_A_EV: begin
            state_in = S_A_RD;
            if (!seg_rd.used && seg_rd.size >= req_ff && take) begin
               found_in     = 1'b1;
               pick_in      = idx_ff[SEG_IDX_W-1:0];
               pick_addr_in = addr_ff;
               pick_left_in = left;
               pick_size_in = seg_rd.size;
               if (first_fit) begin
                  state_in = S_A_CHK;
               end
            end
            addr_in = addr_ff + seg_rd.size + SIZE_W'(1);
            idx_in  = idx_ff + SEG_CNT_W'(1);
         end
         S_A_CHK: begin
            if (!found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_FIT;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else if (proc_count_ff == PROC_CNT_W'(MAX_PROCS) ||
                         (pick_left_ff != '0 && seg_count_ff == SEG_CNT_W'(MAX_SEGS))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else if (pick_left_ff != '0) begin
               idx_in   = seg_count_ff;
               state_in = S_A_UPRD;
            end else begin
               seg_we      = 1'b1;
               seg_wa      = pick_ff;
               seg_wd.used = 1'b1;
               seg_wd.size = pick_size_ff;
               st_in       = pick_addr_ff;
               state_in    = S_A_PROC;
            end
         end
         S_A_UPRD: begin
            if (idx_ff == SEG_CNT_W'(pick_ff) + SEG_CNT_W'(1)) begin
               seg_we      = 1'b1;
               seg_wa      = pick_ff;
               seg_wd.used = 1'b0;
               seg_wd.size = pick_size_ff - req_ff - SIZE_W'(1);
               state_in    = S_A_NEW;
            end else begin
               seg_ra   = SEG_IDX_W'(idx_ff - SEG_CNT_W'(1));
               state_in = S_A_UPWR;
            end
         end
         S_A_UPWR: begin
            seg_we   = 1'b1;
            seg_wa   = idx_ff[SEG_IDX_W-1:0];
            seg_wd   = seg_rd;
            idx_in   = idx_ff - SEG_CNT_W'(1);
            state_in = S_A_UPRD;
         end
         S_A_NEW: begin
            seg_we       = 1'b1;
            seg_wa       = pick_ff + SEG_IDX_W'(1);
            seg_wd.used  = 1'b1;
            seg_wd.size  = req_ff;
            seg_count_in = seg_count_ff + SEG_CNT_W'(1);
            st_in        = pick_addr_ff + pick_size_ff - req_ff;
            state_in     = S_A_PROC;
         end
         S_A_PROC: begin
            proc_we       = 1'b1;
            proc_wa       = proc_count_ff[PROC_IDX_W-1:0];
            proc_wd.owner = id_ff;
            proc_wd.start = st_ff;
            proc_wd.len   = req_ff;
            proc_count_in = proc_count_ff + PROC_CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_addr_in   = st_ff;
            rsp_size_in   = req_ff;
            state_in      = S_IDLE;
         end
         S_R_PRD: begin
            if (PROC_CNT_W'(idx_ff) == proc_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_PROC;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_R_PEV;
            end
         end
         S_R_PEV: begin
            if (proc_rd.owner == id_ff) begin
               pj_in    = idx_ff[PROC_IDX_W-1:0];
               st_in    = proc_rd.start;
               len_in   = proc_rd.len;
               idx_in   = '0;
               state_in = S_R_SRD;
            end else begin
               idx_in   = idx_ff + SEG_CNT_W'(1);
               state_in = S_R_PRD;
            end
         end
         S_R_SRD: begin
            if (idx_ff == seg_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_PROC;
               rsp_addr_in   = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_R_SEV;
            end
         end
         S_R_SEV: begin
            if (addr_ff == st_ff) begin
               k_in     = idx_ff[SEG_IDX_W-1:0];
               ksize_in = seg_rd.size;
               state_in = S_R_NRD;
            end else begin
               prev_free_in = !seg_rd.used;
               prev_size_in = seg_rd.size;
               addr_in      = addr_ff + seg_rd.size + SIZE_W'(1);
               idx_in       = idx_ff + SEG_CNT_W'(1);
               state_in     = S_R_SRD;
            end
         end
         S_R_NRD: begin
            if (SEG_CNT_W'(k_ff) + SEG_CNT_W'(1) < seg_count_ff) begin
               seg_ra   = k_ff + SEG_IDX_W'(1);
               state_in = S_R_NEV;
            end else begin
               seg_we      = 1'b1;
               seg_wa      = k_ff;
               seg_wd.used = 1'b0;
               seg_wd.size = ksize_ff;
               state_in    = S_R_PRV;
            end
         end
         S_R_NEV: begin
            seg_we      = 1'b1;
            seg_wa      = k_ff;
            seg_wd.used = 1'b0;
            if (!seg_rd.used) begin
               seg_wd.size = merged;
               ksize_in    = merged;
               idx_in      = SEG_CNT_W'(k_ff) + SEG_CNT_W'(1);
               sd_ret_in   = 1'b0;
               state_in    = S_SD_RD;
            end else begin
               seg_wd.size = ksize_ff;
               state_in    = S_R_PRV;
            end
         end
         S_R_PRV: begin
            if (k_ff != '0 && prev_free_ff) begin
               seg_we      = 1'b1;
               seg_wa      = k_ff - SEG_IDX_W'(1);
               seg_wd.used = 1'b0;
               seg_wd.size = prev_size_ff + ksize_ff + SIZE_W'(1);
               idx_in      = SEG_CNT_W'(k_ff);
               sd_ret_in   = 1'b1;
               state_in    = S_SD_RD;
            end else begin
               state_in = S_R_PJ;
            end
         end
         S_SD_RD: begin
            if (idx_ff + SEG_CNT_W'(1) >= seg_count_ff) begin
               seg_count_in = seg_count_ff - SEG_CNT_W'(1);
               state_in     = sd_ret_ff ? S_R_PJ : S_R_PRV;
            end else begin
               seg_ra   = SEG_IDX_W'(idx_ff + SEG_CNT_W'(1));
               state_in = S_SD_WR;
            end
         end
         S_SD_WR: begin
            seg_we   = 1'b1;
            seg_wa   = idx_ff[SEG_IDX_W-1:0];
            seg_wd   = seg_rd;
            idx_in   = idx_ff + SEG_CNT_W'(1);
            state_in = S_SD_RD;
         end
         S_R_PJ: begin
            idx_in   = SEG_CNT_W'(pj_ff);
            state_in = S_P_RD;
         end
         S_P_RD: begin
            if (PROC_CNT_W'(idx_ff) + PROC_CNT_W'(1) >= proc_count_ff) begin
               proc_count_in = proc_count_ff - PROC_CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = st_ff;
               rsp_size_in   = len_ff;
               state_in      = S_IDLE;
            end else begin
               proc_ra  = PROC_IDX_W'(idx_ff + SEG_CNT_W'(1));
               state_in = S_P_WR;
            end
         end
         S_P_WR: begin
            proc_we  = 1'b1;
            proc_wa  = idx_ff[PROC_IDX_W-1:0];
            proc_wd  = proc_rd;
            idx_in   = idx_ff + SEG_CNT_W'(1);
            state_in = S_P_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         policy_ff     <= POL_FIRST;
         seg_count_ff  <= SEG_CNT_W'(1);
         proc_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         seg_count_ff  <= seg_count_in;
         proc_count_ff <= proc_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      id_ff         <= id_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      pick_addr_ff  <= pick_addr_in;
      pick_left_ff  <= pick_left_in;
      pick_size_ff  <= pick_size_in;
      pj_ff         <= pj_in;
      st_ff         <= st_in;
      len_ff        <= len_in;
      k_ff          <= k_in;
      ksize_ff      <= ksize_in;
      prev_free_ff  <= prev_free_in;
      prev_size_ff  <= prev_size_in;
      sd_ret_ff     <= sd_ret_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_addr = rsp_addr_ff;
   assign rsp_block_size = rsp_size_ff;

`ifndef SYNTHESIS
   a_seg_count: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff != '0 && seg_count_ff <= SEG_CNT_W'(MAX_SEGS))
      else $error("segment count out of range");
   a_proc_count: assert property (@(posedge clock) disable iff (reset)
      proc_count_ff <= PROC_CNT_W'(MAX_PROCS))
      else $error("process count out of range");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("response while still working");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
`endif

endmodule
